// File: hdl/int64_to_decimal_ascii_macros.svh
// assertion macros for the int64 to decimal text block
`ifndef INT64_TO_DECIMAL_ASCII_MACROS_SVH
`define INT64_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication
`define I2A_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2A_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// shared types and constants for the int64 to decimal text block
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int VALUE_W      = 64;
    localparam int NUM_DIGITS   = 20;
    localparam int DIGIT_W      = 4;
    localparam int CHAR_W       = 7;
    localparam int LEN_W        = 5;
    localparam int BITS_PER_CYC = 4;
    localparam int CONV_CYCLES  = VALUE_W / BITS_PER_CYC;
    localparam int STEP_W       = $clog2(CONV_CYCLES);
    localparam int IDX_W        = $clog2(NUM_DIGITS);

    localparam logic [CHAR_W-1:0]  DIGIT_ZERO   = 7'd48;
    localparam logic [CHAR_W-1:0]  MINUS_SIGN   = 7'd45;
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;

    // classified item handed from the front to the back
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_EMIT
    } back_state_t;

endpackage

// File: hdl/i2a_front.sv
// ----------------------------------------------------------------------------
// i2a_front
// accepts input values and splits them into sign and magnitude
// ----------------------------------------------------------------------------
module i2a_front import i2a_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      item_valid,
    input  logic                      item_ready,
    output item_t                     item
);

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic  take;

    assign s_ready = !valid_reg || item_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (take) begin
            valid_next    = 1'b1;
            item_next.neg = s_value[VALUE_W-1];
            // most negative value wraps to 2^63, which is right as unsigned
            item_next.mag = s_value[VALUE_W-1] ? (~$unsigned(s_value) + 64'd1)
                                               : $unsigned(s_value);
        end else if (item_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hdl/i2a_queue.sv
// ----------------------------------------------------------------------------
// i2a_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module i2a_queue import i2a_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);

    item_t       entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: hdl/i2a_back.sv
// ----------------------------------------------------------------------------
// i2a_back
// binary to bcd conversion, digit count and character output
// ----------------------------------------------------------------------------
module i2a_back import i2a_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_char_code,
    output logic              m_last,
    output logic [LEN_W-1:0]  m_text_length
);

    localparam int BCD_W = NUM_DIGITS * DIGIT_W;

    back_state_t        state_reg, state_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    digit_vec_t         bcd_reg, bcd_next;
    logic               neg_reg, neg_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               sign_reg, sign_next;

    logic               ov_reg, ov_next;
    logic [CHAR_W-1:0]  oc_reg, oc_next;
    logic               ol_reg, ol_next;
    logic [LEN_W-1:0]   on_reg, on_next;

    digit_vec_t         dab_bcd;
    logic [VALUE_W-1:0] dab_mag;
    logic [LEN_W-1:0]   ndig;
    logic               slot_free;
    logic               char_last;

    assign slot_free  = !ov_reg || m_ready;
    assign char_last  = (pos_reg == (len_reg - 5'd1));
    assign item_ready = (state_reg == ST_IDLE);

    // four shift-and-add-3 steps
    always_comb begin
        logic [BCD_W+VALUE_W-1:0] cat;
        dab_bcd = bcd_reg;
        dab_mag = mag_reg;
        for (int s = 0; s < BITS_PER_CYC; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (dab_bcd[d] >= DABBLE_LIMIT) begin
                    dab_bcd[d] = dab_bcd[d] + DABBLE_ADD;
                end
            end
            cat     = {dab_bcd, dab_mag} << 1;
            dab_bcd = cat[BCD_W+VALUE_W-1:VALUE_W];
            dab_mag = cat[VALUE_W-1:0];
        end
    end

    // number of significant digits, at least one
    always_comb begin
        ndig = 5'd1;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_reg[d] != '0) begin
                ndig = LEN_W'(d + 1);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (step_reg == STEP_W'(CONV_CYCLES - 1)) begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free && char_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        len_next  = len_reg;
        pos_next  = pos_reg;
        idx_next  = idx_reg;
        sign_next = sign_reg;
        ov_next   = ov_reg && !m_ready;
        oc_next   = oc_reg;
        ol_next   = ol_reg;
        on_next   = on_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    mag_next  = item.mag;
                    neg_next  = item.neg;
                    bcd_next  = '0;
                    step_next = '0;
                end
            end
            ST_CONV: begin
                mag_next  = dab_mag;
                bcd_next  = dab_bcd;
                step_next = step_reg + STEP_W'(1);
            end
            ST_SIZE: begin
                len_next  = ndig + LEN_W'(neg_reg);
                idx_next  = IDX_W'(ndig - 5'd1);
                pos_next  = '0;
                sign_next = neg_reg;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    ov_next  = 1'b1;
                    ol_next  = char_last;
                    on_next  = len_reg;
                    pos_next = pos_reg + 5'd1;
                    if (sign_reg) begin
                        oc_next   = MINUS_SIGN;
                        sign_next = 1'b0;
                    end else begin
                        oc_next  = DIGIT_ZERO + CHAR_W'(bcd_reg[idx_reg]);
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        step_reg <= step_next;
        len_reg  <= len_next;
        pos_reg  <= pos_next;
        idx_reg  <= idx_next;
        sign_reg <= sign_next;
        oc_reg   <= oc_next;
        ol_reg   <= ol_next;
        on_reg   <= on_next;
    end

    assign m_valid       = ov_reg;
    assign m_char_code   = oc_reg;
    assign m_last        = ol_reg;
    assign m_text_length = on_reg;

endmodule

// File: hdl/int64_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii
// signed 64-bit integer to decimal ascii text, one character per transfer
// ----------------------------------------------------------------------------
// Each accepted value comes out as its decimal text, one character per
// output transfer: a minus sign first for negative values, then the digits
// most significant first, with no leading zeros ('0' for zero). Every
// character carries the total text length, and the final one has m_last set.
// The most negative value prints as "-9223372036854775808". The text length
// is 1 to 20. In the back end a value goes through binary to bcd conversion
// at four bits a cycle, then a step that sizes the text, then one character
// per cycle while the output is taken. The front register and a two-entry
// queue take further values while one is being written out.
// ----------------------------------------------------------------------------
module int64_to_decimal_ascii import i2a_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [CHAR_W-1:0]         m_char_code,
    output logic                      m_last,
    output logic [LEN_W-1:0]          m_text_length
);

    logic  f_valid, f_ready;
    item_t f_item;
    logic  q_valid, q_ready;
    item_t q_item;

    i2a_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    i2a_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    i2a_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (q_valid),
        .item_ready    (q_ready),
        .item          (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_code   (m_char_code),
        .m_last        (m_last),
        .m_text_length (m_text_length)
    );

endmodule

// File: hdl/i2a_checker.sv
// ----------------------------------------------------------------------------
// i2a_checker
// port-level checks on the character output of the top level
// ----------------------------------------------------------------------------
`include "int64_to_decimal_ascii_macros.svh"

module i2a_checker import i2a_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [CHAR_W-1:0]         m_char_code,
    input logic                      m_last,
    input logic [LEN_W-1:0]          m_text_length
);

    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             m_xfer;
    logic             is_digit;

    assign m_xfer   = m_valid && m_ready;
    assign is_digit = (m_char_code >= DIGIT_ZERO) && (m_char_code <= DIGIT_ZERO + 7'd9);

    // characters already transferred in the current text
    always_comb begin
        cnt_next = cnt_reg;
        if (m_xfer) begin
            cnt_next = m_last ? '0 : cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    `I2A_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_char_code) && $stable(m_last) && $stable(m_text_length), "output changed while stalled")
    `I2A_ASSERT_IMP(a_char_set, aclk, aresetn, m_valid, is_digit || (m_char_code == MINUS_SIGN && cnt_reg == '0 && !m_last), "bad character or misplaced sign")
    `I2A_ASSERT_IMP(a_last_len, aclk, aresetn, m_valid && m_last, cnt_reg + 5'd1 == m_text_length, "last flag does not match length")
    `I2A_ASSERT_IMP(a_len_bound, aclk, aresetn, m_valid, cnt_reg < m_text_length && m_text_length <= 5'd20, "text longer than its length")

endmodule

bind int64_to_decimal_ascii i2a_checker u_i2a_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_char_code   (m_char_code),
    .m_last        (m_last),
    .m_text_length (m_text_length)
);
